// ===== rtl/flr_pkg.sv =====
// ----------------------------------------------------------------------------
// flr_pkg: shared types and constants of the fixed-point line rasterizer
// Holds the register map, item codes, control state types and the record
// that carries one candidate pixel to the output stage.
// ----------------------------------------------------------------------------
package flr_pkg;

  // Default geometry of the datapath.
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // Field widths fixed by the frame buffer side.
  localparam int CFG_W   = 11;
  localparam int PIX_W   = 10;
  localparam int ADDR_W  = 20;
  localparam int COLOR_W = 8;

  // Register port geometry.
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 1;

  // Register values after reset.
  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  // Register map: register index is the word address.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_idx_t;

  // Input item function codes.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_NEXT  = 1'b1;

  // Kind of line being walked.
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_VERT   = 2'd1,
    MODE_HORZ   = 2'd2,
    MODE_SLOPED = 2'd3
  } line_mode_t;

  // Sequencer: accepting items, or waiting on the slope divider.
  typedef enum logic {
    CTRL_RUN = 1'b0,
    CTRL_DIV = 1'b1
  } ctrl_state_t;

  // Current register contents.
  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } cfg_t;

  // One stepped candidate, before the address is formed.
  typedef struct packed {
    logic               pixel_valid;
    logic               line_done;
    logic [CFG_W-1:0]   x;
    logic [CFG_W-1:0]   y;
    logic [COLOR_W-1:0] color;
  } pix_t;

endpackage

// ===== rtl/flr_if.sv =====
// ----------------------------------------------------------------------------
// flr_if: valid/ready channels of the line rasterizer
// The request channel carries line set-up and next-pixel items; the pixel
// channel carries one result per next-pixel item.
// ----------------------------------------------------------------------------
interface flr_in_if
  import flr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic [COLOR_W-1:0]           line_color;

  modport source (
    output valid, func, x_start, y_start, x_end, y_end, line_color,
    input  ready
  );
  modport sink (
    input  valid, func, x_start, y_start, x_end, y_end, line_color,
    output ready
  );
endinterface

interface flr_out_if
  import flr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               pixel_valid;
  logic [PIX_W-1:0]   pixel_x;
  logic [PIX_W-1:0]   pixel_y;
  logic [ADDR_W-1:0]  pixel_address;
  logic [COLOR_W-1:0] pixel_color;
  logic               line_done;

  modport source (
    output valid, pixel_valid, pixel_x, pixel_y, pixel_address, pixel_color, line_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_valid, pixel_x, pixel_y, pixel_address, pixel_color, line_done,
    output ready
  );
endinterface

// ===== rtl/flr_cfg.sv =====
// ----------------------------------------------------------------------------
// flr_cfg: register file of the line rasterizer
// Screen width and height behind an APB-style port with zero wait states.
// ----------------------------------------------------------------------------
module flr_cfg
  import flr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [CFG_W-1:0] screen_width;
  logic [CFG_W-1:0] screen_height;
  reg_idx_t         reg_idx;
  logic             wr_en;

  // Word address selects the register; byte lanes are not decoded.
  assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[CFG_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_SCREEN_WIDTH:  prdata = {{(APB_DW-CFG_W){1'b0}}, screen_width};
      REG_SCREEN_HEIGHT: prdata = {{(APB_DW-CFG_W){1'b0}}, screen_height};
      default:           prdata = '0;
    endcase
  end

  assign cfg.width  = screen_width;
  assign cfg.height = screen_height;

endmodule

// ===== rtl/flr_div.sv =====
// ----------------------------------------------------------------------------
// flr_div: serial unsigned divider for the line slope
// Restoring division, one quotient bit per cycle through a single
// subtract-and-compare unit; done pulses for one cycle at the end.
// ----------------------------------------------------------------------------
module flr_div
  import flr_pkg::*;
#(
  parameter int NUM_W = COORD_BITS_DEF + FRAC_BITS_DEF,
  parameter int DEN_W = COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             fits;
  logic             last;

  // Shift in the next dividend bit and try the subtraction.
  assign rem_sh  = {rem, quo[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign fits    = rem_sh >= {1'b0, den};
  assign last    = count == CNT_W'(NUM_W - 1);

  // Sequencing of the iterations.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CNT_W'(1);
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= denom;
      quo <= numer;
    end else if (busy) begin
      rem <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/flr_out.sv =====
// ----------------------------------------------------------------------------
// flr_out: address stage and output register of the line rasterizer
// Forms the linear frame address of a stepped pixel and holds the result
// beat until the receiver takes it.
// ----------------------------------------------------------------------------
module flr_out
  import flr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] width,
  input  logic             pix_valid,
  output logic             pix_ready,
  input  pix_t             pix,
  flr_out_if.source        out_ch
);

  logic [2*CFG_W-1:0] prod;
  logic [2*CFG_W-1:0] addr_sum;

  // Row times stride plus column; candidates that are not written carry zeros.
  assign prod     = pix.y * width;
  assign addr_sum = prod + (2*CFG_W)'(pix.x);

  assign pix_ready = !out_ch.valid || out_ch.ready;

  // Output beat valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (pix_ready) begin
      out_ch.valid <= pix_valid;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (pix_valid && pix_ready) begin
      out_ch.pixel_valid   <= pix.pixel_valid;
      out_ch.line_done     <= pix.line_done;
      out_ch.pixel_x       <= pix.x[PIX_W-1:0];
      out_ch.pixel_y       <= pix.y[PIX_W-1:0];
      out_ch.pixel_address <= addr_sum[ADDR_W-1:0];
      out_ch.pixel_color   <= pix.color;
    end
  end

endmodule

// ===== rtl/fixed_point_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// fixed_point_line_rasterizer: line walker with one candidate pixel per request
// A start beat on in_ch latches two endpoints and a color and returns nothing.
// Each next beat returns exactly one beat on out_ch: a pixel write with its
// frame address, a dropped candidate above row 0, or the end of the line.
// Axis-aligned lines run inclusively and are clipped to the screen; other
// lines step by a signed 13.16 slope from the left end, excluding the right end.
// Screen width and height are set through the APB port; the user must write
// them only while idle, as the block does not enforce it; they reset to 640 by 480.
// A next beat's result passes the step register and then the output register;
// next beats are taken one per cycle while out_ch is not stalled. A start
// beat for an axis line does not hold in_ch.ready low. A start beat for a
// sloped line holds in_ch.ready low while the serial divider forms the slope,
// one quotient bit per cycle.
// Reset is synchronous and leaves the block with no line; a next beat then
// reports the end of the line. When out_ch is stalled, one result waits in
// the output register and one in the step register, after which in_ch.ready
// drops until the receiver takes a beat.
// ----------------------------------------------------------------------------
module fixed_point_line_rasterizer
  import flr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  flr_in_if.sink            in_ch,
  flr_out_if.source         out_ch
);

  localparam int CW    = COORD_BITS + 1;
  localparam int NUM_W = COORD_BITS + FRAC_BITS;
  localparam int SL_W  = NUM_W + 1;
  localparam int RUN_W = NUM_W + 1;
  localparam int ACC_W = 2 * COORD_BITS + FRAC_BITS + 1;
  localparam int RW    = ACC_W - FRAC_BITS;
  localparam int CMP_W = (CW > CFG_W + 1) ? CW : CFG_W + 1;

  cfg_t        cfg;
  ctrl_state_t ctrl_state;
  ctrl_state_t ctrl_state_next;
  line_mode_t  line_mode;

  // Line state.
  logic signed [CW-1:0]         cursor_x;
  logic signed [CW-1:0]         cursor_row;
  logic signed [COORD_BITS-1:0] limit_major;
  logic signed [ACC_W-1:0]      y_accumulator;
  logic signed [SL_W-1:0]       slope_value;
  logic [NUM_W-1:0]             slope_mag;
  logic [NUM_W-1:0]             run_offset;
  logic                         going_down;
  logic                         div_neg;
  logic [COLOR_W-1:0]           held_color;

  // Handshake and divider.
  logic             in_ready;
  logic             in_fire;
  logic             start_fire;
  logic             next_fire;
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  // Step register between the stepper and the address stage.
  logic s1_valid;
  logic s1_ready;
  pix_t s1_data;
  pix_t res;

  // ---- Set-up decode of a start beat ----
  logic signed [COORD_BITS-1:0] xs, ys, xe, ye;
  logic signed [COORD_BITS-1:0] x_lo, x_hi, y_lo, y_hi, y0;
  logic signed [COORD_BITS-1:0] x_lo_c, y_lo_c, y0_c;
  logic signed [CW-1:0]         dx, dy, dx_abs, dy_abs;
  logic                         is_vert, is_horz, is_sloped;
  logic [NUM_W-1:0]             numer;
  logic signed [ACC_W-1:0]      acc_start;

  assign xs = in_ch.x_start;
  assign ys = in_ch.y_start;
  assign xe = in_ch.x_end;
  assign ye = in_ch.y_end;

  assign is_vert   = xs == xe;
  assign is_horz   = !is_vert && (ys == ye);
  assign is_sloped = !is_vert && !is_horz;

  assign x_lo = (xs < xe) ? xs : xe;
  assign x_hi = (xs < xe) ? xe : xs;
  assign y_lo = (ys < ye) ? ys : ye;
  assign y_hi = (ys < ye) ? ye : ys;
  assign y0   = (xs < xe) ? ys : ye;

  // Clamp at column or row zero.
  assign x_lo_c = x_lo[COORD_BITS-1] ? '0 : x_lo;
  assign y_lo_c = y_lo[COORD_BITS-1] ? '0 : y_lo;
  assign y0_c   = y0[COORD_BITS-1] ? '0 : y0;

  assign dx     = CW'(xe) - CW'(xs);
  assign dy     = CW'(ye) - CW'(ys);
  assign dx_abs = dx[CW-1] ? -dx : dx;
  assign dy_abs = dy[CW-1] ? -dy : dy;
  assign numer  = {dy_abs[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};

  assign acc_start = {{(ACC_W-COORD_BITS-FRAC_BITS){1'b0}}, y0_c, {FRAC_BITS{1'b0}}};

  assign in_fire    = in_ch.valid && in_ready;
  assign start_fire = in_fire && (in_ch.func == FUNC_START);
  assign next_fire  = in_fire && (in_ch.func == FUNC_NEXT);

  // ---- Stepper: compares against the current screen size ----
  logic signed [CMP_W-1:0] cx_e, cr_e, lim_e, w_e, h_e;
  logic signed [CMP_W-1:0] min_lw, min_lw1, min_lh1;
  logic signed [ACC_W-1:0] run_e, row_sum;
  logic signed [RW-1:0]    row, h_row;
  logic [RUN_W-1:0]        run_step;
  logic                    col_done;
  logic                    finish_line, vert_adv, horz_adv, slope_adv;

  assign cx_e  = CMP_W'(cursor_x);
  assign cr_e  = CMP_W'(cursor_row);
  assign lim_e = CMP_W'(limit_major);
  assign w_e   = CMP_W'($signed({1'b0, cfg.width}));
  assign h_e   = CMP_W'($signed({1'b0, cfg.height}));

  assign min_lw  = (lim_e < w_e) ? lim_e : w_e;
  assign min_lw1 = (lim_e < w_e - CMP_W'(1)) ? lim_e : w_e - CMP_W'(1);
  assign min_lh1 = (lim_e < h_e - CMP_W'(1)) ? lim_e : h_e - CMP_W'(1);

  // Row of the current candidate: accumulator plus or minus run, floored.
  assign run_e   = $signed({{(ACC_W-NUM_W){1'b0}}, run_offset});
  assign row_sum = going_down ? y_accumulator + run_e : y_accumulator - run_e;
  assign row     = row_sum[ACC_W-1:FRAC_BITS];
  assign h_row   = $signed({{(RW-CFG_W){1'b0}}, cfg.height});

  // Next run offset; the column is finished once it reaches the magnitude.
  assign run_step = {1'b0, run_offset} + (RUN_W'(1) << FRAC_BITS);
  assign col_done = run_step >= {1'b0, slope_mag};

  // Decision for one next beat.
  always_comb begin
    res         = '0;
    finish_line = 1'b0;
    vert_adv    = 1'b0;
    horz_adv    = 1'b0;
    slope_adv   = 1'b0;
    unique case (line_mode)
      MODE_VERT: begin
        if (cx_e < 0 || cx_e >= w_e || cr_e > min_lh1) begin
          finish_line = 1'b1;
        end else begin
          res.pixel_valid = 1'b1;
          res.x           = cx_e[CFG_W-1:0];
          res.y           = cr_e[CFG_W-1:0];
          res.color       = held_color;
          vert_adv        = 1'b1;
        end
      end
      MODE_HORZ: begin
        if (cr_e < 0 || cr_e >= h_e || cx_e > min_lw1) begin
          finish_line = 1'b1;
        end else begin
          res.pixel_valid = 1'b1;
          res.x           = cx_e[CFG_W-1:0];
          res.y           = cr_e[CFG_W-1:0];
          res.color       = held_color;
          horz_adv        = 1'b1;
        end
      end
      MODE_SLOPED: begin
        if (cx_e >= min_lw || row >= h_row) begin
          finish_line = 1'b1;
        end else begin
          slope_adv = 1'b1;
          // A candidate above row zero is dropped but still stepped.
          if (!row[RW-1]) begin
            res.pixel_valid = 1'b1;
            res.x           = cx_e[CFG_W-1:0];
            res.y           = row[CFG_W-1:0];
            res.color       = held_color;
          end
        end
      end
      default: finish_line = 1'b1;
    endcase
    res.line_done = finish_line;
  end

  // ---- Line state update ----
  always_ff @(posedge clk) begin
    if (rst) begin
      line_mode     <= MODE_IDLE;
      cursor_x      <= '0;
      cursor_row    <= '0;
      limit_major   <= '0;
      y_accumulator <= '0;
      slope_value   <= '0;
      slope_mag     <= '0;
      run_offset    <= '0;
      going_down    <= 1'b0;
      div_neg       <= 1'b0;
      held_color    <= '0;
    end else if (start_fire) begin
      held_color <= in_ch.line_color;
      run_offset <= '0;
      if (is_vert) begin
        line_mode   <= MODE_VERT;
        cursor_x    <= CW'(xs);
        cursor_row  <= CW'(y_lo_c);
        limit_major <= y_hi;
      end else if (is_horz) begin
        line_mode   <= MODE_HORZ;
        cursor_row  <= CW'(ys);
        cursor_x    <= CW'(x_lo_c);
        limit_major <= x_hi;
      end else begin
        line_mode     <= MODE_IDLE;
        y_accumulator <= acc_start;
        cursor_x      <= CW'(x_lo_c);
        limit_major   <= x_hi;
        div_neg       <= dx[CW-1] ^ dy[CW-1];
      end
    end else if (next_fire) begin
      if (finish_line) begin
        line_mode <= MODE_IDLE;
      end
      if (vert_adv) begin
        cursor_row <= cursor_row + CW'(1);
      end
      if (horz_adv) begin
        cursor_x <= cursor_x + CW'(1);
      end
      if (slope_adv) begin
        if (col_done) begin
          run_offset    <= '0;
          y_accumulator <= y_accumulator + ACC_W'(slope_value);
          cursor_x      <= cursor_x + CW'(1);
        end else begin
          run_offset <= run_step[NUM_W-1:0];
        end
      end
    end else if (div_done) begin
      // Slope truncated toward zero: sign applied to the magnitude quotient.
      slope_value <= div_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
      slope_mag   <= div_quo;
      going_down  <= !div_neg && (|div_quo);
      line_mode   <= (|div_quo) ? MODE_SLOPED : MODE_IDLE;
    end
  end

  // ---- Sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_state <= CTRL_RUN;
    end else begin
      ctrl_state <= ctrl_state_next;
    end
  end

  // Next state.
  always_comb begin
    ctrl_state_next = ctrl_state;
    unique case (ctrl_state)
      CTRL_RUN: if (div_start) ctrl_state_next = CTRL_DIV;
      CTRL_DIV: if (div_done) ctrl_state_next = CTRL_RUN;
      default:  ctrl_state_next = CTRL_RUN;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    unique case (ctrl_state)
      CTRL_RUN: begin
        in_ready  = !s1_valid || s1_ready;
        div_start = in_ch.valid && in_ready && (in_ch.func == FUNC_START) && is_sloped;
      end
      CTRL_DIV: begin
        in_ready  = 1'b0;
        div_start = 1'b0;
      end
      default: ;
    endcase
  end

  assign in_ch.ready = in_ready;

  // ---- Step register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (next_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (next_fire) begin
      s1_data <= res;
    end
  end

  // ---- Submodules ----
  flr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  flr_div #(
    .NUM_W (NUM_W),
    .DEN_W (COORD_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (numer),
    .denom    (dx_abs[COORD_BITS-1:0]),
    .done     (div_done),
    .quotient (div_quo)
  );

  flr_out u_out (
    .clk       (clk),
    .rst       (rst),
    .width     (cfg.width),
    .pix_valid (s1_valid),
    .pix_ready (s1_ready),
    .pix       (s1_data),
    .out_ch    (out_ch)
  );

  // ---- Assertions ----
`ifndef ASSERT_OFF
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> ctrl_state == CTRL_DIV)
    else $error("slope divider finished outside of the divide phase");

  a_start_enters_div: assert property (@(posedge clk) disable iff (rst)
    div_start |=> ctrl_state == CTRL_DIV && !in_ch.ready)
    else $error("sloped line set-up did not block the request channel");

  a_run_below_mag: assert property (@(posedge clk) disable iff (rst)
    line_mode == MODE_SLOPED |-> run_offset < slope_mag)
    else $error("run offset reached the slope magnitude");

  a_step_reg_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_ready |=> s1_valid && $stable(s1_data))
    else $error("stepped pixel overwritten while the output stage was full");
`endif

endmodule
